FILE: rtl/core/vsse_pkg.sv
// Shared types and constants for the value stack with search and edit.
// Used by vsse_ctrl, vsse_dpath and value_stack_with_search_edit_core.
`default_nettype none

package vsse_pkg;

    localparam int DEPTH    = 16;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int OUT_CNT_W = 5;

    localparam logic signed [DATA_W-1:0] EMPTY_READ = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_PUSH       = 3'd0,
        OP_POP        = 3'd1,
        OP_TOP        = 3'd2,
        OP_EXISTS     = 3'd3,
        OP_REMOVE     = 3'd4,
        OP_INS_BEFORE = 3'd5,
        OP_INS_AFTER  = 3'd6,
        OP_IGNORE     = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EDIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/core/vsse_ctrl.sv
// Controller for the value stack: accept/edit state machine and result handshake.
// Depends on vsse_pkg for the state enum and the command struct.
`default_nettype none

module vsse_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output vsse_pkg::t_cmd     o_cmd
);

    vsse_pkg::t_state r_state;
    vsse_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vsse_pkg::S_IDLE: begin
                if (i_in_valid) n_state = vsse_pkg::S_EDIT;
            end
            vsse_pkg::S_EDIT: begin
                if (w_slot_free) n_state = vsse_pkg::S_IDLE;
            end
            default: n_state = vsse_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            vsse_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            vsse_pkg::S_EDIT: begin
                // hold the edit until the result register can take the word
                o_cmd.commit = w_slot_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    assign n_out_valid = o_cmd.commit || (r_out_valid && !i_out_ready);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vsse_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/vsse_dpath.sv
// Datapath for the value stack: entry cells, parallel compare with first-match
// pick, shift network and result registers. Depends on vsse_pkg.
`default_nettype none

module vsse_dpath (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire vsse_pkg::t_cmd                       i_cmd,
    input  wire logic [2:0]                           i_operation,
    input  wire logic signed [vsse_pkg::DATA_W-1:0]   i_value,
    input  wire logic signed [vsse_pkg::DATA_W-1:0]   i_new_value,
    output logic signed [vsse_pkg::DATA_W-1:0]        o_read_value,
    output logic                                      o_found,
    output logic [1:0]                                o_status,
    output logic [vsse_pkg::OUT_CNT_W-1:0]            o_entry_count,
    output logic                                      o_is_empty
);

    localparam int DEPTH = vsse_pkg::DEPTH;
    localparam int CNT_W = vsse_pkg::CNT_W;

    logic signed [vsse_pkg::DATA_W-1:0] r_cell [DEPTH];
    logic signed [vsse_pkg::DATA_W-1:0] n_cell [DEPTH];
    logic [CNT_W-1:0]                   r_count;
    logic [CNT_W-1:0]                   n_count;

    vsse_pkg::t_op                      r_op;
    logic signed [vsse_pkg::DATA_W-1:0] r_key;
    logic signed [vsse_pkg::DATA_W-1:0] r_nv;
    logic [DEPTH-1:0]                   r_first;
    logic [DEPTH-1:0]                   r_pre;
    logic                               r_hit;

    logic [DEPTH-1:0]                   w_match;
    logic [DEPTH-1:0]                   w_pre;

    logic signed [vsse_pkg::DATA_W-1:0] r_read_value;
    logic signed [vsse_pkg::DATA_W-1:0] n_read_value;
    logic                               r_found;
    logic                               n_found;
    vsse_pkg::t_status                  r_status;
    vsse_pkg::t_status                  n_status;

    logic [DEPTH-1:0]                   w_take_new;
    logic [DEPTH-1:0]                   w_shift_dn;
    logic [DEPTH-1:0]                   w_shift_up;
    logic signed [vsse_pkg::DATA_W-1:0] w_ins_val;
    logic                               w_empty;
    logic                               w_full;

    // Compare every held cell against the incoming key.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_match[i] = (CNT_W'(i) < r_count) && (r_cell[i] == i_value);
        end
        // w_pre[i]: some match lies above position i
        w_pre[0] = 1'b0;
        for (int i = 1; i < DEPTH; i++) begin
            w_pre[i] = w_pre[i-1] || w_match[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= vsse_pkg::t_op'(i_operation);
            r_key   <= i_value;
            r_nv    <= i_new_value;
            r_first <= w_match & ~w_pre;
            r_pre   <= w_pre;
            r_hit   <= |w_match;
        end
    end

    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_ins_val = (r_op == vsse_pkg::OP_PUSH) ? r_key : r_nv;

    // Decode the edit: which cells take the new word, which shift down or up.
    always_comb begin
        w_take_new   = '0;
        w_shift_dn   = '0;
        w_shift_up   = '0;
        n_count      = r_count;
        n_read_value = '0;
        n_found      = 1'b0;
        n_status     = vsse_pkg::ST_OK;
        unique case (r_op)
            vsse_pkg::OP_PUSH: begin
                if (w_full) begin
                    n_status = vsse_pkg::ST_FULL;
                end else begin
                    w_take_new[0] = 1'b1;
                    w_shift_dn    = ~DEPTH'(1);
                    n_count       = r_count + CNT_W'(1);
                end
            end
            vsse_pkg::OP_POP, vsse_pkg::OP_TOP: begin
                if (w_empty) begin
                    n_read_value = vsse_pkg::EMPTY_READ;
                    n_status     = vsse_pkg::ST_EMPTY;
                end else begin
                    n_read_value = r_cell[0];
                    if (r_op == vsse_pkg::OP_POP) begin
                        w_shift_up = '1;
                        n_count    = r_count - CNT_W'(1);
                    end
                end
            end
            vsse_pkg::OP_EXISTS, vsse_pkg::OP_REMOVE,
            vsse_pkg::OP_INS_BEFORE, vsse_pkg::OP_INS_AFTER: begin
                if (w_empty) begin
                    n_status = vsse_pkg::ST_EMPTY;
                end else if (!r_hit) begin
                    n_status = vsse_pkg::ST_NOTFOUND;
                end else begin
                    n_found = 1'b1;
                    if (r_op == vsse_pkg::OP_REMOVE) begin
                        w_shift_up = r_first | r_pre;
                        n_count    = r_count - CNT_W'(1);
                    end else if (r_op != vsse_pkg::OP_EXISTS) begin
                        if (w_full) begin
                            n_status = vsse_pkg::ST_FULL;
                        end else if (r_op == vsse_pkg::OP_INS_BEFORE) begin
                            w_take_new = r_first;
                            w_shift_dn = r_pre;
                            n_count    = r_count + CNT_W'(1);
                        end else begin
                            // insert one place below the match
                            w_take_new = r_first << 1;
                            w_shift_dn = r_pre << 1;
                            n_count    = r_count + CNT_W'(1);
                        end
                    end
                end
            end
            vsse_pkg::OP_IGNORE: begin
                n_status = vsse_pkg::ST_OK;
            end
            default: n_status = vsse_pkg::ST_OK;
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [vsse_pkg::DATA_W-1:0] w_prev;
        logic signed [vsse_pkg::DATA_W-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = r_cell[g];
        end else begin : g_rest
            assign w_prev = r_cell[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next = r_cell[g];
        end else begin : g_inner
            assign w_next = r_cell[g+1];
        end

        always_comb begin
            priority if (w_take_new[g]) n_cell[g] = w_ins_val;
            else if (w_shift_dn[g])     n_cell[g] = w_prev;
            else if (w_shift_up[g])     n_cell[g] = w_next;
            else                        n_cell[g] = r_cell[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_cell       <= n_cell;
            r_read_value <= n_read_value;
            r_found      <= n_found;
            r_status     <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    // Count moves only on commit, which waits for the previous word to leave.
    assign o_read_value  = r_read_value;
    assign o_found       = r_found;
    assign o_status      = r_status;
    assign o_entry_count = vsse_pkg::OUT_CNT_W'(r_count);
    assign o_is_empty    = w_empty;

endmodule

`default_nettype wire

FILE: rtl/core/value_stack_with_search_edit_core.sv
// Value stack with search, remove and insert: top level tying controller to datapath.
// Depends on vsse_pkg, vsse_ctrl and vsse_dpath.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one word: an operation code
//   (push, pop, top, exists, remove, insert_before, insert_after), a key or push
//   value, and the value to insert. Output channel (o_out_valid / i_out_ready)
//   returns one word per input: read value, found flag, status, entry count
//   and empty flag.
//   Timing: a word is compared against all cells in parallel in its accept
//   cycle, and the first-match pick is registered; the shift and result
//   register update happen in the edit state, once the result register is
//   free. The accept/edit pair of the controller takes no new word until the
//   last one is committed. A new word is accepted while the previous result waits.
//   Stall: if the receiver holds i_out_ready low, the edit of the next word
//   waits until the result register frees up, and no further input is taken.
//   Reset (synchronous, active low): stack is empty, no result pending. Cell
//   contents are not cleared; only held positions are ever read.
`default_nettype none

module value_stack_with_search_edit_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [2:0]                           i_operation,
    input  wire logic signed [vsse_pkg::DATA_W-1:0]   i_value,
    input  wire logic signed [vsse_pkg::DATA_W-1:0]   i_new_value,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [vsse_pkg::DATA_W-1:0]        o_read_value,
    output logic                                      o_found,
    output logic [1:0]                                o_status,
    output logic [vsse_pkg::OUT_CNT_W-1:0]            o_entry_count,
    output logic                                      o_is_empty
);

    vsse_pkg::t_cmd w_cmd;

    vsse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    vsse_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_new_value   (i_new_value),
        .o_read_value  (o_read_value),
        .o_found       (o_found),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a word is still being edited");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == vsse_pkg::ST_EMPTY) |-> o_is_empty)
        else $error("empty status reported with entries held");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == vsse_pkg::ST_FULL) |-> !o_is_empty)
        else $error("full status reported on an empty stack");

    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |->
            (o_status == vsse_pkg::ST_OK || o_status == vsse_pkg::ST_FULL))
        else $error("match reported with empty or not-found status");

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking bench for value_stack_with_search_edit_core: random and directed stack
// operations, an in-bench shadow stack that predicts each result word, random stalls.
// Depends on vsse_pkg and the core RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ITEM_TARGET    = 900;
    localparam logic signed [vsse_pkg::DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [vsse_pkg::DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;

    typedef struct {
        vsse_pkg::t_op                      op;
        logic signed [vsse_pkg::DATA_W-1:0] key;
        logic signed [vsse_pkg::DATA_W-1:0] nv;
        int                                 gap;
        bit                                 drain;
    } t_stack_req;

    typedef struct packed {
        logic signed [vsse_pkg::DATA_W-1:0] read_val;
        logic                               found;
        vsse_pkg::t_status                  status;
        logic [vsse_pkg::OUT_CNT_W-1:0]     count;
        logic                               empty;
    } t_stack_result;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic [2:0]                         i_operation = '0;
    logic signed [vsse_pkg::DATA_W-1:0] i_value = '0;
    logic signed [vsse_pkg::DATA_W-1:0] i_new_value = '0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic signed [vsse_pkg::DATA_W-1:0] o_read_value;
    logic                               o_found;
    logic [1:0]                         o_status;
    logic [vsse_pkg::OUT_CNT_W-1:0]     o_entry_count;
    logic                               o_is_empty;

    t_stack_req    req_q[$];
    t_stack_result result_q[$];

    logic signed [vsse_pkg::DATA_W-1:0] shadow_stack [vsse_pkg::DEPTH];
    int                                 shadow_count = 0;

    int mismatches = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    int calm_left = 0;

    value_stack_with_search_edit_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_new_value   (i_new_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_value  (o_read_value),
        .o_found       (o_found),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty)
    );

    always #5 i_clk = ~i_clk;

    // Mostly zero, sometimes a short pause, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void stack_place(int pos, logic signed [vsse_pkg::DATA_W-1:0] v);
        for (int i = shadow_count; i > pos; i--)
            shadow_stack[i] = shadow_stack[i-1];
        shadow_stack[pos] = v;
        shadow_count++;
    endfunction

    function automatic void stack_drop(int pos);
        for (int i = pos; i + 1 < shadow_count; i++)
            shadow_stack[i] = shadow_stack[i+1];
        shadow_count--;
    endfunction

    // Apply one operation to the shadow stack and return the result word it produces.
    function automatic t_stack_result stack_step(vsse_pkg::t_op op,
                                                 logic signed [vsse_pkg::DATA_W-1:0] key,
                                                 logic signed [vsse_pkg::DATA_W-1:0] nv);
        t_stack_result res;
        int            hit;
        res = '0;
        res.status = vsse_pkg::ST_OK;
        hit = -1;
        case (op)
            vsse_pkg::OP_PUSH: begin
                if (shadow_count >= vsse_pkg::DEPTH) res.status = vsse_pkg::ST_FULL;
                else stack_place(0, key);
            end
            vsse_pkg::OP_POP, vsse_pkg::OP_TOP: begin
                if (shadow_count == 0) begin
                    res.read_val = vsse_pkg::EMPTY_READ;
                    res.status   = vsse_pkg::ST_EMPTY;
                end else begin
                    res.read_val = shadow_stack[0];
                    if (op == vsse_pkg::OP_POP) stack_drop(0);
                end
            end
            vsse_pkg::OP_EXISTS, vsse_pkg::OP_REMOVE,
            vsse_pkg::OP_INS_BEFORE, vsse_pkg::OP_INS_AFTER: begin
                if (shadow_count == 0) begin
                    res.status = vsse_pkg::ST_EMPTY;
                end else begin
                    for (int i = shadow_count - 1; i >= 0; i--)
                        if (shadow_stack[i] == key) hit = i;
                    if (hit < 0) begin
                        res.status = vsse_pkg::ST_NOTFOUND;
                    end else begin
                        res.found = 1'b1;
                        if (op == vsse_pkg::OP_REMOVE) begin
                            stack_drop(hit);
                        end else if (op != vsse_pkg::OP_EXISTS) begin
                            if (shadow_count >= vsse_pkg::DEPTH)
                                res.status = vsse_pkg::ST_FULL;
                            else
                                stack_place(op == vsse_pkg::OP_INS_BEFORE ? hit : hit + 1,
                                            nv);
                        end
                    end
                end
            end
            default: ;
        endcase
        res.count = vsse_pkg::OUT_CNT_W'(shadow_count);
        res.empty = (shadow_count == 0);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic add_req(input vsse_pkg::t_op op,
                           input logic signed [vsse_pkg::DATA_W-1:0] key,
                           input logic signed [vsse_pkg::DATA_W-1:0] nv);
        t_stack_req req;
        req.op    = op;
        req.key   = key;
        req.nv    = nv;
        req.gap   = pick_gap();
        req.drain = 1'b0;
        req_q.push_back(req);
    endtask

    // Input side: predict on every accepted word, then load the next one after its gap.
    always @(posedge i_clk) begin
        t_stack_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                result_q.push_back(stack_step(vsse_pkg::t_op'(i_operation), i_value,
                                              i_new_value));
            if (!i_in_valid || o_in_ready) begin
                if (req_q.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (req_q[0].gap != 0) begin
                    nxt = req_q[0];
                    nxt.gap = nxt.gap - 1;
                    req_q[0] = nxt;
                    i_in_valid <= 1'b0;
                end else if (req_q[0].drain && result_q.size() != 0) begin
                    // hold until every outstanding result has come back
                    i_in_valid <= 1'b0;
                end else begin
                    nxt = req_q.pop_front();
                    i_in_valid  <= 1'b1;
                    i_operation <= nxt.op;
                    i_value     <= nxt.key;
                    i_new_value <= nxt.nv;
                end
            end
        end
    end

    // Output side: compare each result word, then pick the next ready pattern.
    always @(posedge i_clk) begin
        t_stack_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result word with nothing pending, read_value %0h status %0d",
                             $time, o_read_value, o_status);
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    check_field("read_value", want.read_val, o_read_value);
                    check_field("found", want.found, o_found);
                    check_field("status", want.status, o_status);
                    check_field("entry_count", want.count, o_entry_count);
                    check_field("is_empty", want.empty, o_is_empty);
                end
            end
            if (calm_left > 0) begin
                calm_left   <= calm_left - 1;
                i_out_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left  <= stall_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 199) == 0) calm_left <= $urandom_range(50, 150);
                else stall_left <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, no handshake for %0d cycles", $time, idle_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic signed [vsse_pkg::DATA_W-1:0] pool [8];
        logic signed [vsse_pkg::DATA_W-1:0] key;
        logic signed [vsse_pkg::DATA_W-1:0] nv;
        t_stack_req                         req;
        vsse_pkg::t_op                      op;
        int                                 mode;
        int                                 block_left;
        int                                 calm;
        int                                 kept;
        int                                 r;
        bit                                 hold_next;

        // Empty-stack corner cases and the ignored code.
        add_req(vsse_pkg::OP_POP, 32'sd0, 32'sd0);
        add_req(vsse_pkg::OP_TOP, MOST_POS, 32'sd0);
        add_req(vsse_pkg::OP_EXISTS, MOST_NEG, 32'sd0);
        add_req(vsse_pkg::OP_REMOVE, 32'sd0, 32'sd0);
        add_req(vsse_pkg::OP_INS_BEFORE, -32'sd1, MOST_POS);
        add_req(vsse_pkg::OP_INS_AFTER, MOST_POS, MOST_NEG);
        add_req(vsse_pkg::OP_IGNORE, -32'sd1, -32'sd1);
        // Extremes, then searches that hit top, middle and bottom, and two that miss.
        add_req(vsse_pkg::OP_PUSH, MOST_NEG, 32'sd0);
        add_req(vsse_pkg::OP_PUSH, MOST_POS, 32'sd0);
        add_req(vsse_pkg::OP_PUSH, 32'sd0, 32'sd0);
        add_req(vsse_pkg::OP_PUSH, -32'sd1, 32'sd0);
        add_req(vsse_pkg::OP_TOP, 32'sd0, 32'sd0);
        add_req(vsse_pkg::OP_EXISTS, MOST_NEG, 32'sd0);
        add_req(vsse_pkg::OP_EXISTS, 32'sd5, 32'sd0);
        add_req(vsse_pkg::OP_INS_BEFORE, -32'sd1, 32'sh5555_5555);
        add_req(vsse_pkg::OP_INS_AFTER, MOST_NEG, 32'shaaaa_aaaa);
        add_req(vsse_pkg::OP_REMOVE, 32'sd0, 32'sd0);
        add_req(vsse_pkg::OP_INS_AFTER, 32'sd7, 32'sd1);
        add_req(vsse_pkg::OP_IGNORE, 32'sd0, 32'sd0);
        add_req(vsse_pkg::OP_POP, 32'sd0, 32'sd0);
        add_req(vsse_pkg::OP_TOP, 32'sd0, 32'sd0);

        // Random part: fill, drain and mixed stretches over a small key pool so that
        // searches hit often and the stack reaches both full and empty.
        pool[0] = MOST_NEG;
        pool[1] = MOST_POS;
        pool[2] = 32'sd0;
        pool[3] = -32'sd1;
        pool[4] = 32'sd1;
        block_left = 0;
        calm = 0;
        kept = 0;
        mode = 0;
        hold_next = 1'b1;
        while (kept < ITEM_TARGET) begin
            if (block_left == 0) begin
                mode = $urandom_range(0, 2);
                block_left = $urandom_range(30, 80);
                for (int i = 5; i < 8; i++) pool[i] = $urandom;
            end
            block_left--;
            r = $urandom_range(0, 99);
            case (mode)
                0: begin
                    if (r < 45) op = vsse_pkg::OP_PUSH;
                    else if (r < 60) op = vsse_pkg::OP_INS_BEFORE;
                    else if (r < 75) op = vsse_pkg::OP_INS_AFTER;
                    else if (r < 83) op = vsse_pkg::OP_EXISTS;
                    else if (r < 88) op = vsse_pkg::OP_TOP;
                    else if (r < 93) op = vsse_pkg::OP_POP;
                    else if (r < 98) op = vsse_pkg::OP_REMOVE;
                    else op = vsse_pkg::OP_IGNORE;
                end
                1: begin
                    if (r < 35) op = vsse_pkg::OP_POP;
                    else if (r < 65) op = vsse_pkg::OP_REMOVE;
                    else if (r < 75) op = vsse_pkg::OP_PUSH;
                    else if (r < 83) op = vsse_pkg::OP_TOP;
                    else if (r < 90) op = vsse_pkg::OP_EXISTS;
                    else if (r < 95) op = vsse_pkg::OP_INS_BEFORE;
                    else if (r < 99) op = vsse_pkg::OP_INS_AFTER;
                    else op = vsse_pkg::OP_IGNORE;
                end
                default: begin
                    if (r == 0) op = vsse_pkg::OP_IGNORE;
                    else op = vsse_pkg::t_op'($urandom_range(0, 6));
                end
            endcase
            if ($urandom_range(0, 99) < 85) key = pool[$urandom_range(0, 7)];
            else key = $urandom;
            if ($urandom_range(0, 1) == 0) nv = pool[$urandom_range(0, 7)];
            else nv = $urandom;
            req.op  = op;
            req.key = key;
            req.nv  = nv;
            if (calm > 0) begin
                calm--;
                req.gap = 0;
            end else begin
                req.gap = pick_gap();
                if ($urandom_range(0, 99) == 0) calm = $urandom_range(20, 60);
            end
            req.drain = hold_next || ($urandom_range(0, 149) == 0);
            hold_next = 1'b0;
            req_q.push_back(req);
            if (op != vsse_pkg::OP_IGNORE) kept++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() != 0 || i_in_valid || result_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
